FILE: rtl/pal_pkg.sv
// Package: shared types and constants for the positional array list.
package pal_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 5;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int VAL_W    = 32;
  localparam int FOUND_W  = 4;
  localparam int COUNT_W  = 5;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             do_ins;
    logic             do_del;
    logic [IDX_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: rtl/pal_cell.sv
// One list slot: holds an entry, shifts with its neighbors, compares on find.
module pal_cell
  import pal_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [VAL_W-1:0] left_data,
  input  logic [VAL_W-1:0] right_data,
  output logic [VAL_W-1:0] data,
  output logic             match
);

  logic [VAL_W-1:0] entry_r;
  logic [VAL_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.do_ins) begin
      if (cell_idx > ctl.pos) begin
        entry_nxt = left_data;
      end else if (cell_idx == ctl.pos) begin
        entry_nxt = ctl.value;
      end
    end else if (ctl.do_del) begin
      if (cell_idx >= ctl.pos) begin
        entry_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign data  = entry_r;
  assign match = (entry_r == ctl.value);

endmodule

FILE: rtl/positional_array_list.sv
// Top level: list controller, row of cells and output register.
//
//   channel | dir | tdata fields (low bit up)
//   in_     | in  | operation[1:0], value[33:2], position[38:34], zero pad
//   out_    | out | status[1:0], found_position[5:2], count[10:6], zero pad
//
// One item per cycle: every cell shifts or compares at once, and the count and
// status are resolved in the same cycle, so a result is registered in the cycle
// after its transfer. The output register lets the next item in while the
// result is taken. Reset clears the count and the output valid; entries stay
// undefined and are never read above the count. A stall on out_ holds in_.
module positional_array_list
  import pal_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // operation, value, position
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // status, found_position, count
);

  logic [1:0]       op_raw;
  logic [VAL_W-1:0] in_value;
  logic [POS_W-1:0] in_pos;
  logic             in_xfer;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  status_t          status_r;
  logic [FOUND_W-1:0] found_r;
  logic [COUNT_W-1:0] count_out_r;

  status_t          status_nxt;
  logic [IDX_W-1:0] found_idx;
  logic             any_match;
  logic             full;

  cell_ctl_t        ctl;
  logic [VAL_W-1:0] cell_data  [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  logic [CAPACITY-1:0] hit;

  assign op_raw   = in_tdata[1:0];
  assign in_value = in_tdata[33:2];
  assign in_pos   = in_tdata[38:34];
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign pos_x = CMP_W'(in_pos);
  assign cnt_x = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(CAPACITY));

  // Lowest valid cell holding the value.
  always_comb begin
    found_idx = '0;
    any_match = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      hit[i] = cell_match[i] && (CNT_W'(i) < count_r);
      if (hit[i]) begin
        found_idx = IDX_W'(i);
        any_match = 1'b1;
      end
    end
  end

  always_comb begin
    ctl.do_ins = 1'b0;
    ctl.do_del = 1'b0;
    ctl.pos    = pos_x[IDX_W-1:0];
    ctl.value  = in_value;
    status_nxt = ST_OK;
    count_nxt  = count_r;
    case (op_raw)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (pos_x > cnt_x) begin
          status_nxt = ST_BAD_POS;
        end else begin
          ctl.do_ins = in_xfer;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_BAD_POS;
        end else begin
          ctl.do_del = in_xfer;
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        if (!any_match) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] left_in;
    logic [VAL_W-1:0] right_in;
    if (g == 0) begin : g_first
      assign left_in = in_value;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    pal_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cell_idx   (IDX_W'(g)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[g]),
      .match      (cell_match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      status_r    <= status_nxt;
      found_r     <= (op_raw == OP_FIND && any_match) ? FOUND_W'(found_idx) : '0;
      count_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, count_out_r, found_r, status_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_ins |=> count_r == CNT_W'($past(count_r) + CNT_W'(1)))
    else $error("insert did not grow count");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_del |=> count_r == CNT_W'($past(count_r) - CNT_W'(1)))
    else $error("delete did not shrink count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> count_out_r == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("transfer without result");

endmodule
